// ===== rtl/matrix3x3_inverse_defines.svh =====
// assertion macros shared by the 3x3 matrix inverse rtl
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// same-cycle implication
`define M3INV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("m3inv check failed");

// next-cycle implication
`define M3INV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("m3inv check failed");

`endif

// ===== rtl/m3inv_pkg.sv =====
// shared constants and types of the 3x3 matrix inverse
`default_nettype none
package m3inv_pkg;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int IO_WIDTH       = 32;
   localparam int N_ELEM         = 9;

   typedef logic [N_ELEM-1:0] lane_mask_type;

   // sideband that travels with an item through the divider
   typedef struct packed {
      logic                 singular;
      lane_mask_type        neg;
      lane_mask_type        ovf;
      logic [IO_WIDTH-1:0]  det_out;
   } side_type;

   // one finished result item
   typedef struct packed {
      logic [N_ELEM-1:0][IO_WIDTH-1:0] inv;
      logic [IO_WIDTH-1:0]             det;
      logic                            singular;
   } res_type;
endpackage
`default_nettype wire

// ===== rtl/m3inv_if.sv =====
// request and response channel interfaces of the 3x3 matrix inverse
`default_nettype none
interface m3inv_req_if;
   import m3inv_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

   modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   input ready);
   modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                   output ready);
endinterface

interface m3inv_rsp_if;
   import m3inv_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [IO_WIDTH-1:0] inv00, inv01, inv02, inv10, inv11, inv12;
   logic signed [IO_WIDTH-1:0] inv20, inv21, inv22, determinant;
   logic                       singular;

   modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, determinant, singular, input ready);
   modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                   inv20, inv21, inv22, determinant, singular, output ready);
endinterface
`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
// Inverse and determinant of a 3x3 fixed-point matrix by the adjugate.
// Pipeline: four cofactor/determinant stages, two prep stages, one divider
//   stage per quotient bit, one output register.
// Throughput: one item per cycle while the skid entry is free; a two-entry
//   output buffer parts the sides.
// Reset: synchronous, active high; clears all valid bits, data is not reset.
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module matrix3x3_inverse #(
   parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF,
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   m3inv_req_if.sink   req_ch,
   m3inv_rsp_if.source rsp_ch
);
   import m3inv_pkg::*;

   localparam int W         = ELEM_WIDTH;
   localparam int NUM_W     = 2 * W + 2 * FRAC_BITS;
   localparam int REM_WIDTH = (NUM_W > 4 * W) ? NUM_W : 4 * W;

   logic                 advance;
   logic signed [W-1:0]  elem [N_ELEM];
   logic                 front_valid;
   logic signed [2*W-1:0] adj [N_ELEM];
   logic signed [3*W:0]  det;
   logic                 valid_ch [W+1];
   logic [REM_WIDTH-1:0] rem_ch [W+1][N_ELEM];
   logic [W-1:0]         quo_ch [W+1][N_ELEM];
   logic [3*W-1:0]       dmag_ch [W+1];
   side_type             side_ch [W+1];
   res_type              res;

   // input elements, low W bits of each port, upper bits dropped
   assign elem[0] = req_ch.a00[W-1:0];
   assign elem[1] = req_ch.a01[W-1:0];
   assign elem[2] = req_ch.a02[W-1:0];
   assign elem[3] = req_ch.a10[W-1:0];
   assign elem[4] = req_ch.a11[W-1:0];
   assign elem[5] = req_ch.a12[W-1:0];
   assign elem[6] = req_ch.a20[W-1:0];
   assign elem[7] = req_ch.a21[W-1:0];
   assign elem[8] = req_ch.a22[W-1:0];
   assign req_ch.ready = advance;

   m3inv_front #(.ELEM_WIDTH(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .elem_i    (elem),
      .out_valid (front_valid),
      .adj_o     (adj),
      .det_o     (det)
   );

   m3inv_prep #(.ELEM_WIDTH(W), .FRAC_BITS(FRAC_BITS), .REM_WIDTH(REM_WIDTH)) u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (front_valid),
      .adj_i     (adj),
      .det_i     (det),
      .out_valid (valid_ch[0]),
      .rem_o     (rem_ch[0]),
      .dmag_o    (dmag_ch[0]),
      .side_o    (side_ch[0])
   );

   // quotient starts at zero
   for (genvar k = 0; k < N_ELEM; k++) begin : g_quo_init
      assign quo_ch[0][k] = '0;
   end

   // divider chain, most significant quotient bit first
   for (genvar s = 0; s < W; s++) begin : g_div
      m3inv_div_step #(.ELEM_WIDTH(W), .REM_WIDTH(REM_WIDTH), .SHIFT(W - 1 - s)) u_step (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_ch[s]),
         .rem_i     (rem_ch[s]),
         .quo_i     (quo_ch[s]),
         .dmag_i    (dmag_ch[s]),
         .side_i    (side_ch[s]),
         .out_valid (valid_ch[s+1]),
         .rem_o     (rem_ch[s+1]),
         .quo_o     (quo_ch[s+1]),
         .dmag_o    (dmag_ch[s+1]),
         .side_o    (side_ch[s+1])
      );
   end

   m3inv_out_buf #(.ELEM_WIDTH(W)) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (valid_ch[W]),
      .quo_i     (quo_ch[W]),
      .side_i    (side_ch[W]),
      .advance   (advance),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .res_o     (res)
   );

   // result item fields
   assign rsp_ch.inv00       = res.inv[0];
   assign rsp_ch.inv01       = res.inv[1];
   assign rsp_ch.inv02       = res.inv[2];
   assign rsp_ch.inv10       = res.inv[3];
   assign rsp_ch.inv11       = res.inv[4];
   assign rsp_ch.inv12       = res.inv[5];
   assign rsp_ch.inv20       = res.inv[6];
   assign rsp_ch.inv21       = res.inv[7];
   assign rsp_ch.inv22       = res.inv[8];
   assign rsp_ch.determinant = res.det;
   assign rsp_ch.singular    = res.singular;

   // pipeline checks
   `M3INV_ASSERT_NEXT(a_stall_holds_last, clock, reset, !advance && valid_ch[W],
      valid_ch[W])
   `M3INV_ASSERT_NOW(a_singular_zeroes, clock, reset, rsp_ch.valid && rsp_ch.singular,
      rsp_ch.determinant == 0 && rsp_ch.inv00 == 0 && rsp_ch.inv11 == 0
      && rsp_ch.inv22 == 0)
   `M3INV_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_ch.valid && !rsp_ch.ready,
      rsp_ch.valid)
endmodule
`default_nettype wire

// ===== rtl/m3inv_front.sv =====
// cofactor and determinant stages of the 3x3 matrix inverse
`default_nettype none
module m3inv_front #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic signed [ELEM_WIDTH-1:0]  elem_i [m3inv_pkg::N_ELEM],
   output logic                          out_valid,
   output logic signed [2*ELEM_WIDTH-1:0] adj_o [m3inv_pkg::N_ELEM],
   output logic signed [3*ELEM_WIDTH:0]  det_o
);
   import m3inv_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2 * W;
   localparam int LW = 2 * W + 1;
   localparam int DW = 3 * W + 1;

   // operand pairs of each cofactor: adj = e[IX1]*e[IX2] - e[IX3]*e[IX4]
   localparam int IX1 [N_ELEM] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
   localparam int IX2 [N_ELEM] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
   localparam int IX3 [N_ELEM] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
   localparam int IX4 [N_ELEM] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};
   // cofactors used by the first-row expansion
   localparam int CIX [3] = '{0, 3, 6};

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [PW-1:0] pa_in [N_ELEM];
   logic signed [PW-1:0] pb_in [N_ELEM];
   logic signed [PW-1:0] pa_ff [N_ELEM];
   logic signed [PW-1:0] pb_ff [N_ELEM];
   logic signed [W-1:0]  row1_ff [3];
   logic signed [W-1:0]  row2_ff [3];
   logic signed [PW-1:0] adj2_in [N_ELEM];
   logic signed [PW-1:0] adj2_ff [N_ELEM];
   logic signed [PW-1:0] adj3_ff [N_ELEM];
   logic signed [PW-1:0] adj4_ff [N_ELEM];
   logic signed [PW-1:0] ph_in [3];
   logic signed [PW-1:0] ph_ff [3];
   logic signed [LW-1:0] pl_in [3];
   logic signed [LW-1:0] pl_ff [3];
   logic signed [DW-1:0] det_in;
   logic signed [DW-1:0] det_ff;

   // stage 1: the eighteen element products
   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         pa_in[k] = PW'(elem_i[IX1[k]]) * PW'(elem_i[IX2[k]]);
         pb_in[k] = PW'(elem_i[IX3[k]]) * PW'(elem_i[IX4[k]]);
      end
   end

   // stage 2: cofactors
   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         adj2_in[k] = pa_ff[k] - pb_ff[k];
      end
   end

   // stage 3: first-row element times cofactor, split into high and low halves
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         ph_in[j] = PW'(row2_ff[j]) * PW'($signed(adj2_ff[CIX[j]][PW-1:W]));
         pl_in[j] = LW'(row2_ff[j]) * LW'($signed({1'b0, adj2_ff[CIX[j]][W-1:0]}));
      end
   end

   // stage 4: recombine halves and sum the three terms
   always_comb begin
      det_in = (DW'(ph_ff[0]) <<< W) + DW'(pl_ff[0])
             + (DW'(ph_ff[1]) <<< W) + DW'(pl_ff[1])
             + (DW'(ph_ff[2]) <<< W) + DW'(pl_ff[2]);
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         pa_ff   <= pa_in;
         pb_ff   <= pb_in;
         row1_ff <= elem_i[0:2];
         row2_ff <= row1_ff;
         adj2_ff <= adj2_in;
         ph_ff   <= ph_in;
         pl_ff   <= pl_in;
         adj3_ff <= adj2_ff;
         det_ff  <= det_in;
         adj4_ff <= adj3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign adj_o     = adj4_ff;
   assign det_o     = det_ff;
endmodule
`default_nettype wire

// ===== rtl/m3inv_prep.sv =====
// magnitude, overflow test and determinant output stages
`default_nettype none
module m3inv_prep #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF,
   parameter int REM_WIDTH  = 4 * m3inv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           in_valid,
   input  logic signed [2*ELEM_WIDTH-1:0] adj_i [m3inv_pkg::N_ELEM],
   input  logic signed [3*ELEM_WIDTH:0]   det_i,
   output logic                           out_valid,
   output logic [REM_WIDTH-1:0]           rem_o [m3inv_pkg::N_ELEM],
   output logic [3*ELEM_WIDTH-1:0]        dmag_o,
   output m3inv_pkg::side_type            side_o
);
   import m3inv_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2 * W;
   localparam int MW = 3 * W;
   localparam int DW = 3 * W + 1;
   localparam logic [REM_WIDTH-1:0] LIM     = REM_WIDTH'({1'b0, {(W-1){1'b1}}});
   localparam logic [REM_WIDTH-1:0] MAG_MIN = REM_WIDTH'({1'b1, {(W-1){1'b0}}});

   logic                 dneg;
   logic [MW-1:0]        dmag5_in;
   logic [PW-1:0]        amag5_in [N_ELEM];
   lane_mask_type        neg5_in;
   logic                 v5_ff, v6_ff;
   logic                 zero5_ff, dneg5_ff;
   logic [MW-1:0]        dmag5_ff, dmag6_ff;
   logic [PW-1:0]        amag5_ff [N_ELEM];
   lane_mask_type        neg5_ff;
   logic [REM_WIDTH-1:0] num6_in [N_ELEM];
   logic [REM_WIDTH-1:0] rem6_ff [N_ELEM];
   logic [REM_WIDTH-1:0] dsh;
   logic [REM_WIDTH-1:0] dq;
   logic [W-1:0]         dsat;
   lane_mask_type        ovf6_in;
   side_type             side6_in, side6_ff;

   // stage 5: signs and magnitudes
   always_comb begin
      dneg     = det_i[DW-1];
      dmag5_in = dneg ? MW'(-det_i) : MW'(det_i);
      for (int k = 0; k < N_ELEM; k++) begin
         amag5_in[k] = adj_i[k][PW-1] ? PW'(-adj_i[k]) : PW'(adj_i[k]);
         neg5_in[k]  = adj_i[k][PW-1] ^ dneg;
      end
   end

   // stage 6: scaled numerators and quotient overflow test
   always_comb begin
      dsh = REM_WIDTH'(dmag5_ff) << W;
      for (int k = 0; k < N_ELEM; k++) begin
         num6_in[k] = REM_WIDTH'(amag5_ff[k]) << (2 * FRAC_BITS);
         ovf6_in[k] = num6_in[k] >= dsh;
      end
   end

   // stage 6: determinant truncated toward zero and saturated
   always_comb begin
      dq = REM_WIDTH'(dmag5_ff) >> (2 * FRAC_BITS);
      priority if (!dneg5_ff) begin
         dsat = (dq > LIM) ? W'(LIM) : dq[W-1:0];
      end else begin
         dsat = (dq > MAG_MIN) ? W'(MAG_MIN) : W'(~dq[W-1:0] + 1'b1);
      end
      side6_in.singular = zero5_ff;
      side6_in.neg      = neg5_ff;
      side6_in.ovf      = ovf6_in;
      side6_in.det_out  = zero5_ff ? '0 : IO_WIDTH'($signed(dsat));
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (advance) begin
         v5_ff <= in_valid;
         v6_ff <= v5_ff;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         zero5_ff <= (det_i == '0);
         dneg5_ff <= dneg;
         dmag5_ff <= dmag5_in;
         amag5_ff <= amag5_in;
         neg5_ff  <= neg5_in;
         rem6_ff  <= num6_in;
         dmag6_ff <= dmag5_ff;
         side6_ff <= side6_in;
      end
   end

   assign out_valid = v6_ff;
   assign rem_o     = rem6_ff;
   assign dmag_o    = dmag6_ff;
   assign side_o    = side6_ff;
endmodule
`default_nettype wire

// ===== rtl/m3inv_div_step.sv =====
// one restoring-division stage: one quotient bit for all nine lanes
`default_nettype none
module m3inv_div_step #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
   parameter int REM_WIDTH  = 4 * m3inv_pkg::ELEM_WIDTH_DEF,
   parameter int SHIFT      = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic                      in_valid,
   input  logic [REM_WIDTH-1:0]      rem_i [m3inv_pkg::N_ELEM],
   input  logic [ELEM_WIDTH-1:0]     quo_i [m3inv_pkg::N_ELEM],
   input  logic [3*ELEM_WIDTH-1:0]   dmag_i,
   input  m3inv_pkg::side_type       side_i,
   output logic                      out_valid,
   output logic [REM_WIDTH-1:0]      rem_o [m3inv_pkg::N_ELEM],
   output logic [ELEM_WIDTH-1:0]     quo_o [m3inv_pkg::N_ELEM],
   output logic [3*ELEM_WIDTH-1:0]   dmag_o,
   output m3inv_pkg::side_type       side_o
);
   import m3inv_pkg::*;

   logic [REM_WIDTH-1:0]    dsh;
   lane_mask_type           take;
   logic [REM_WIDTH-1:0]    rem_in [N_ELEM];
   logic [ELEM_WIDTH-1:0]   quo_in [N_ELEM];
   logic                    valid_ff;
   logic [REM_WIDTH-1:0]    rem_ff [N_ELEM];
   logic [ELEM_WIDTH-1:0]   quo_ff [N_ELEM];
   logic [3*ELEM_WIDTH-1:0] dmag_ff;
   side_type                side_ff;

   // trial subtract of the aligned divisor
   always_comb begin
      dsh = REM_WIDTH'(dmag_i) << SHIFT;
      for (int k = 0; k < N_ELEM; k++) begin
         take[k]          = rem_i[k] >= dsh;
         rem_in[k]        = take[k] ? rem_i[k] - dsh : rem_i[k];
         quo_in[k]        = quo_i[k];
         quo_in[k][SHIFT] = take[k];
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         dmag_ff <= dmag_i;
         side_ff <= side_i;
      end
   end

   assign out_valid = valid_ff;
   assign rem_o     = rem_ff;
   assign quo_o     = quo_ff;
   assign dmag_o    = dmag_ff;
   assign side_o    = side_ff;
endmodule
`default_nettype wire

// ===== rtl/m3inv_out_buf.sv =====
// quotient saturation and two-entry output buffer
`default_nettype none
`include "matrix3x3_inverse_defines.svh"
module m3inv_out_buf #(
   parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [ELEM_WIDTH-1:0] quo_i [m3inv_pkg::N_ELEM],
   input  m3inv_pkg::side_type   side_i,
   output logic                  advance,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output m3inv_pkg::res_type    res_o
);
   import m3inv_pkg::*;

   localparam int W = ELEM_WIDTH;
   localparam logic [W-1:0] LIMQ = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINQ = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] sat_val [N_ELEM];
   res_type      res_new;
   logic         push, pop;
   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   res_type      main_ff, main_in;
   res_type      skid_ff, skid_in;

   // saturate each quotient with its sign; all zero for a singular matrix
   always_comb begin
      for (int k = 0; k < N_ELEM; k++) begin
         priority if (side_i.singular) begin
            sat_val[k] = '0;
         end else if (!side_i.neg[k]) begin
            sat_val[k] = (side_i.ovf[k] || quo_i[k] > LIMQ) ? LIMQ : quo_i[k];
         end else begin
            sat_val[k] = (side_i.ovf[k] || quo_i[k] > MINQ) ? MINQ
                                                            : W'(~quo_i[k] + 1'b1);
         end
         res_new.inv[k] = IO_WIDTH'($signed(sat_val[k]));
      end
      res_new.det      = side_i.det_out;
      res_new.singular = side_i.singular;
   end

   // buffer control: the pipeline stalls only when the skid entry is taken
   assign advance = !skid_valid_ff;
   assign push    = in_valid && advance;
   assign pop     = main_valid_ff && rsp_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      priority if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push && (pop || !main_valid_ff)) begin
         main_in       = res_new;
         main_valid_in = 1'b1;
      end else if (push) begin
         skid_in       = res_new;
         skid_valid_in = 1'b1;
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = main_valid_ff;
   assign res_o     = main_ff;

   // buffer checks
   `M3INV_ASSERT_NOW(a_skid_needs_main, clock, reset, skid_valid_ff, main_valid_ff)
   `M3INV_ASSERT_NEXT(a_blocked_push_skids, clock, reset,
      push && main_valid_ff && !rsp_ready, skid_valid_ff)
   `M3INV_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && rsp_ready,
      main_valid_ff && !skid_valid_ff)
endmodule
`default_nettype wire
